// ----- sv/tlvs_pkg.sv -----
// ----------------------------------------------------------------------------
// TLV tag search package
// Shared types, register indexes and constants of the TLV tag search block.
// ----------------------------------------------------------------------------
package tlvs_pkg;

	localparam int MAX_AREA_BYTES_DEF = 1024;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int POS_W = 11;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WANTED_TAG   = 3'd0,
		REG_END_TAG      = 3'd1,
		REG_PADDING_BYTE = 3'd2,
		REG_AREA_SIZE    = 3'd3,
		REG_START_OFFSET = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_FOUND     = 2'd0,
		ST_END       = 2'd1,
		ST_NOFIT     = 2'd2,
		ST_EXHAUSTED = 2'd3
	} status_t;

	typedef struct packed {
		logic [15:0]      wanted_tag;
		logic [15:0]      end_tag;
		logic [7:0]       padding_byte;
		logic [POS_W-1:0] area_size;
		logic [7:0]       start_offset;
	} cfg_t;

	typedef struct packed {
		status_t          status;
		logic [POS_W-1:0] value_offset;
		logic [POS_W-1:0] value_length;
		logic [POS_W-1:0] tag_offset;
	} result_t;

endpackage

// ----- sv/tlvs_cfg.sv -----
// ----------------------------------------------------------------------------
// TLV tag search configuration registers
// Holds the search registers written through the configuration channel.
// ----------------------------------------------------------------------------
module tlvs_cfg
	import tlvs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wanted_tag   <= 16'd0;
			cfg_q.end_tag      <= 16'd0;
			cfg_q.padding_byte <= 8'd255;
			cfg_q.area_size    <= 11'd248;
			cfg_q.start_offset <= 8'd8;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_WANTED_TAG:   cfg_q.wanted_tag   <= wr_data;
				REG_END_TAG:      cfg_q.end_tag      <= wr_data;
				REG_PADDING_BYTE: cfg_q.padding_byte <= wr_data[7:0];
				REG_AREA_SIZE:    cfg_q.area_size    <= wr_data[POS_W-1:0];
				REG_START_OFFSET: cfg_q.start_offset <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- sv/tlvs_parser.sv -----
// ----------------------------------------------------------------------------
// TLV tag search parser
// Per-byte record parser state and the step that updates it for each byte.
// ----------------------------------------------------------------------------
module tlvs_parser
	import tlvs_pkg::*;
#(
	parameter int MAX_AREA_BYTES = MAX_AREA_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       step_en,
	input  logic [7:0] byte_in,
	input  logic       first_in,
	output logic       res_valid,
	output result_t    res
);

	localparam logic [16:0] MAX_W = 17'(MAX_AREA_BYTES);

	typedef enum logic [4:0] {
		PH_TYPE_LO = 5'b00001,
		PH_TYPE_HI = 5'b00010,
		PH_LEN_LO  = 5'b00100,
		PH_LEN_HI  = 5'b01000,
		PH_VALUE   = 5'b10000
	} phase_t;

	phase_t           phase_q, phase_e, phase_n;
	logic [POS_W-1:0] pos_q, pos_e, pos_n;
	logic [15:0]      type_q, type_e, type_n;
	logic [7:0]       len_lo_q, len_lo_e, len_lo_n;
	logic [POS_W-1:0] skip_q, skip_e, skip_n;
	logic [POS_W-1:0] rs_q, rs_e, rs_n;
	logic             done_q, done_e, done_n;

	logic [POS_W-1:0] size;
	logic [POS_W:0]   p_plus1;
	logic [POS_W:0]   rs_plus4;
	logic [15:0]      type_full;
	logic [15:0]      len_full;
	logic [17:0]      fit_need;
	logic [POS_W-1:0] skip_dec;
	logic             fin;
	logic             at_start;
	result_t          res_c;

	always_comb begin
		if ({6'd0, cfg.area_size} > MAX_W) begin
			size = MAX_W[POS_W-1:0];
		end else begin
			size = cfg.area_size;
		end
	end

	always_comb begin
		if (first_in) begin
			pos_e    = '0;
			phase_e  = PH_TYPE_LO;
			type_e   = '0;
			len_lo_e = '0;
			skip_e   = '0;
			rs_e     = '0;
			done_e   = 1'b0;
		end else begin
			pos_e    = pos_q;
			phase_e  = phase_q;
			type_e   = type_q;
			len_lo_e = len_lo_q;
			skip_e   = skip_q;
			rs_e     = rs_q;
			done_e   = done_q;
		end
	end

	assign p_plus1   = {1'b0, pos_e} + 12'd1;
	assign rs_plus4  = {1'b0, rs_e} + 12'd4;
	assign type_full = {byte_in, type_e[7:0]};
	assign len_full  = {byte_in, len_lo_e};
	assign fit_need  = {7'd0, rs_e} + 18'd4 + {2'd0, len_full};
	assign skip_dec  = (skip_e == '0) ? '0 : skip_e - 11'd1;

	always_comb begin
		fin      = 1'b0;
		at_start = 1'b0;
		res_c    = '{status: ST_EXHAUSTED, value_offset: '0, value_length: '0,
			tag_offset: '0};
		pos_n    = pos_e;
		phase_n  = phase_e;
		type_n   = type_e;
		len_lo_n = len_lo_e;
		skip_n   = skip_e;
		rs_n     = rs_e;
		done_n   = done_e;
		if (!done_e) begin
			if (pos_e >= size) begin
				fin = 1'b1;
			end else begin
				pos_n = p_plus1[POS_W-1:0];
				case (phase_e)
					PH_TYPE_LO: begin
						if (byte_in == cfg.padding_byte) begin
							at_start = 1'b1;
						end else if (p_plus1 + 12'd1 > {1'b0, size}) begin
							fin          = 1'b1;
							res_c.status = ST_NOFIT;
						end else begin
							rs_n    = pos_e;
							type_n  = {8'd0, byte_in};
							phase_n = PH_TYPE_HI;
						end
					end
					PH_TYPE_HI: begin
						type_n = type_full;
						if (type_full == cfg.end_tag) begin
							fin          = 1'b1;
							res_c.status = ST_END;
						end else if (rs_plus4 > {1'b0, size}) begin
							fin          = 1'b1;
							res_c.status = ST_NOFIT;
						end else begin
							phase_n = PH_LEN_LO;
						end
					end
					PH_LEN_LO: begin
						len_lo_n = byte_in;
						phase_n  = PH_LEN_HI;
					end
					PH_LEN_HI: begin
						if (fit_need > {7'd0, size}) begin
							fin          = 1'b1;
							res_c.status = ST_NOFIT;
						end else if (type_e == cfg.wanted_tag) begin
							fin                = 1'b1;
							res_c.status       = ST_FOUND;
							res_c.value_offset = rs_plus4[POS_W-1:0];
							res_c.value_length = len_full[POS_W-1:0];
							res_c.tag_offset   = {3'd0, cfg.start_offset} + rs_e;
						end else begin
							skip_n = len_full[POS_W-1:0];
							if (len_full == '0) begin
								phase_n  = PH_TYPE_LO;
								at_start = 1'b1;
							end else begin
								phase_n = PH_VALUE;
							end
						end
					end
					default: begin
						skip_n = skip_dec;
						if (skip_dec == '0) begin
							phase_n  = PH_TYPE_LO;
							at_start = 1'b1;
						end
					end
				endcase
				if (!fin && at_start && p_plus1 >= {1'b0, size}) begin
					fin          = 1'b1;
					res_c.status = ST_EXHAUSTED;
				end
			end
			if (fin) begin
				done_n  = 1'b1;
				phase_n = PH_TYPE_LO;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			phase_q  <= PH_TYPE_LO;
			type_q   <= '0;
			len_lo_q <= '0;
			skip_q   <= '0;
			rs_q     <= '0;
			done_q   <= 1'b1;
		end else if (step_en) begin
			pos_q    <= pos_n;
			phase_q  <= phase_n;
			type_q   <= type_n;
			len_lo_q <= len_lo_n;
			skip_q   <= skip_n;
			rs_q     <= rs_n;
			done_q   <= done_n;
		end
	end

	assign res_valid = step_en && fin;
	assign res       = res_c;

endmodule

// ----- sv/tlv_header_tag_search.sv -----
// ----------------------------------------------------------------------------
// TLV header tag search
// A result is presented at the output once the input register has loaded the
// byte that decides it and the result register has then loaded the parser's
// result; a stalled output holds the byte in the input register.
// Throughput: one byte per cycle while the output is not stalled.
// Reset clears the pipeline valid flags and the parser waits for a first byte;
// configuration registers return to their documented defaults.
// ----------------------------------------------------------------------------
module tlv_header_tag_search
	import tlvs_pkg::*;
#(
	parameter int MAX_AREA_BYTES = MAX_AREA_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            data_byte,
	input  logic                  first_byte,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            status,
	output logic [POS_W-1:0]      value_offset,
	output logic [POS_W-1:0]      value_length,
	output logic [POS_W-1:0]      tag_offset
);

	cfg_t       cfg;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       first_s1;
	logic       advance;
	logic       res_valid;
	result_t    res;
	logic       out_valid_q;
	result_t    out_q;

	assign cfg_ready = 1'b1;

	tlvs_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1  <= data_byte;
			first_s1 <= first_byte;
		end
	end

	tlvs_parser #(
		.MAX_AREA_BYTES (MAX_AREA_BYTES)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.step_en   (advance),
		.byte_in   (byte_s1),
		.first_in  (first_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_q.status;
	assign value_offset = out_q.value_offset;
	assign value_length = out_q.value_length;
	assign tag_offset   = out_q.tag_offset;

	// A result never overwrites one that is still waiting at the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !res_valid)
		else $error("result produced while output beat is stalled");

	// An accepted input beat always lands in the input register.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted input beat lost");

	// A found value always starts after the four header bytes of its record.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status == ST_FOUND |-> out_q.value_offset >= 11'd4)
		else $error("found value offset inside record header");

	// Results other than found carry zero offsets and length.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status != ST_FOUND |->
		out_q.value_offset == '0 && out_q.value_length == '0 &&
		out_q.tag_offset == '0)
		else $error("nonzero fields on a result other than found");

endmodule
